// File: hw/rtl/mrc_pkg.sv
// ----------------------------------------------------------------------------
// mrc_pkg
// Shared types, status codes and the byte-wide CRC-16/MODBUS update for the
// read-holding-register reply checker.
// ----------------------------------------------------------------------------
package mrc_pkg;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned WORD_W  = 16;
   localparam int unsigned STAT_W  = 2;

   localparam logic [BYTE_W-1:0] FUNC_READ_HOLDING = 8'h03;
   localparam logic [BYTE_W-1:0] DATA_BYTE_COUNT   = 8'h02;
   localparam int unsigned       MIN_FRAME_BYTES   = 7;

   localparam logic [WORD_W-1:0] CRC_INIT = 16'hFFFF;
   localparam logic [WORD_W-1:0] CRC_POLY = 16'hA001;

   localparam logic [BYTE_W-1:0] SLAVE_ADDR_RESET = 8'h50;

   localparam logic [STAT_W-1:0] STATUS_OK     = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_FORMAT = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_CRC    = 2'd2;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [WORD_W-1:0] reg_value;
   } result_type;

   // one byte through the reflected crc, one bit per step
   function automatic logic [WORD_W-1:0] crc_byte(input logic [WORD_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
      logic [WORD_W-1:0] c;
      c = crc ^ {{(WORD_W-BYTE_W){1'b0}}, b};
      for (int k = 0; k < BYTE_W; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

// File: hw/rtl/mrc_if.sv
// ----------------------------------------------------------------------------
// mrc channel interfaces
// Valid/ready channels for received bytes and for reply status words.
// ----------------------------------------------------------------------------
interface mrc_req_if;
   logic                        valid;
   logic                        ready;
   logic [mrc_pkg::BYTE_W-1:0]  rx_byte;
   logic                        frame_end;

   modport source (output valid, output rx_byte, output frame_end, input ready);
   modport sink   (input valid, input rx_byte, input frame_end, output ready);
endinterface

interface mrc_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [mrc_pkg::STAT_W-1:0]  status;
   logic [mrc_pkg::WORD_W-1:0]  reg_value;

   modport source (output valid, output status, output reg_value, input ready);
   modport sink   (input valid, input status, input reg_value, output ready);
endinterface

// File: hw/rtl/mrc_frame.sv
// ----------------------------------------------------------------------------
// mrc_frame
// Per-frame state: byte count, header check, data bytes, tail bytes and the
// running crc with two lagged copies. Judges the frame on its final byte.
// ----------------------------------------------------------------------------
module mrc_frame #(
   parameter int unsigned MAX_FRAME_BYTES = 512
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [mrc_pkg::BYTE_W-1:0]    slave_address,
   input  logic                          step,
   input  logic [mrc_pkg::BYTE_W-1:0]    rx_byte,
   input  logic                          frame_end,
   output mrc_pkg::result_type           result
);

   localparam int unsigned CNT_W = $clog2(MAX_FRAME_BYTES + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FRAME_BYTES);
   localparam logic [CNT_W-1:0] CNT_MIN = CNT_W'(mrc_pkg::MIN_FRAME_BYTES);

   logic [CNT_W-1:0]            cnt_ff,  cnt_in;
   logic                        hdr_ff,  hdr_in;
   logic [mrc_pkg::WORD_W-1:0]  crc_ff,  crc_in;
   logic [mrc_pkg::WORD_W-1:0]  lag0_ff, lag0_in;
   logic [mrc_pkg::WORD_W-1:0]  lag1_ff, lag1_in;
   logic [mrc_pkg::WORD_W-1:0]  data_ff, data_in;
   logic [mrc_pkg::WORD_W-1:0]  tail_ff, tail_in;
   logic                        take;
   logic [mrc_pkg::WORD_W-1:0]  crc_got;

   always_comb begin
      take    = (cnt_ff != CNT_MAX);
      cnt_in  = cnt_ff;
      hdr_in  = hdr_ff;
      crc_in  = crc_ff;
      lag0_in = lag0_ff;
      lag1_in = lag1_ff;
      data_in = data_ff;
      tail_in = tail_ff;
      if (take) begin
         if (cnt_ff == CNT_W'(0) && rx_byte != slave_address) begin
            hdr_in = 1'b0;
         end
         if (cnt_ff == CNT_W'(1) && rx_byte != mrc_pkg::FUNC_READ_HOLDING) begin
            hdr_in = 1'b0;
         end
         if (cnt_ff == CNT_W'(2) && rx_byte != mrc_pkg::DATA_BYTE_COUNT) begin
            hdr_in = 1'b0;
         end
         if (cnt_ff == CNT_W'(3)) begin
            data_in = {rx_byte, data_ff[mrc_pkg::BYTE_W-1:0]};
         end
         if (cnt_ff == CNT_W'(4)) begin
            data_in = {data_ff[mrc_pkg::WORD_W-1:mrc_pkg::BYTE_W], rx_byte};
         end
         lag1_in = lag0_ff;
         lag0_in = crc_ff;
         crc_in  = mrc_pkg::crc_byte(crc_ff, rx_byte);
         tail_in = {tail_ff[mrc_pkg::BYTE_W-1:0], rx_byte};
         cnt_in  = cnt_ff + CNT_W'(1);
      end
   end

   // crc travels low byte first
   assign crc_got = {tail_in[mrc_pkg::BYTE_W-1:0],
                     tail_in[mrc_pkg::WORD_W-1:mrc_pkg::BYTE_W]};

   always_comb begin
      result.status    = mrc_pkg::STATUS_OK;
      result.reg_value = data_in;
      if (cnt_in < CNT_MIN || !hdr_in) begin
         result.status    = mrc_pkg::STATUS_FORMAT;
         result.reg_value = '0;
      end else if (crc_got != lag1_in) begin
         result.status    = mrc_pkg::STATUS_CRC;
         result.reg_value = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (step && frame_end)) begin
         cnt_ff  <= '0;
         hdr_ff  <= 1'b1;
         crc_ff  <= mrc_pkg::CRC_INIT;
         lag0_ff <= mrc_pkg::CRC_INIT;
         lag1_ff <= mrc_pkg::CRC_INIT;
         data_ff <= '0;
         tail_ff <= '0;
      end else if (step) begin
         cnt_ff  <= cnt_in;
         hdr_ff  <= hdr_in;
         crc_ff  <= crc_in;
         lag0_ff <= lag0_in;
         lag1_ff <= lag1_in;
         data_ff <= data_in;
         tail_ff <= tail_in;
      end
   end

endmodule

// File: hw/rtl/modbus_register_reply_checker.sv
// ----------------------------------------------------------------------------
// modbus_register_reply_checker
// Checks a Modbus RTU read-holding-register reply, one received byte per
// word, and gives one status word per frame on its final byte.
// ----------------------------------------------------------------------------
// Takes one byte per clock with no gaps needed; the final byte passes the
// input register, then the byte-wide crc update and frame check into the
// result register. Input is held off only while a final byte waits behind
// an untaken status word. status 0 is ok with reg_value the big-endian
// register, 1 is a short frame or header mismatch, 2 is a crc error;
// reg_value is zero unless ok. csr_wr_data sets the expected device address
// (0x50 after reset); the user must write it only while idle, unenforced.
module modbus_register_reply_checker #(
   parameter int unsigned MAX_FRAME_BYTES = 512
) (
   input  logic                          clock,
   input  logic                          reset,
   mrc_req_if.sink                       req_chan,
   mrc_rsp_if.source                     rsp_chan,
   input  logic                          csr_wr_en,
   input  logic [mrc_pkg::BYTE_W-1:0]    csr_wr_data
);

   logic [mrc_pkg::BYTE_W-1:0]  addr_ff;
   logic                        in_vld_ff;
   logic [mrc_pkg::BYTE_W-1:0]  in_byte_ff;
   logic                        in_last_ff;
   logic                        rsp_vld_ff, rsp_vld_in;
   mrc_pkg::result_type         rsp_ff;
   mrc_pkg::result_type         result;
   logic                        advance;
   logic                        req_take;

   assign advance  = in_vld_ff && (!in_last_ff || !rsp_vld_ff || rsp_chan.ready);
   assign req_chan.ready = !in_vld_ff || advance;
   assign req_take = req_chan.valid && req_chan.ready;

   mrc_frame #(
      .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
   ) u_frame (
      .clock         (clock),
      .reset         (reset),
      .slave_address (addr_ff),
      .step          (advance),
      .rx_byte       (in_byte_ff),
      .frame_end     (in_last_ff),
      .result        (result)
   );

   always_comb begin
      rsp_vld_in = rsp_vld_ff && !rsp_chan.ready;
      if (advance && in_last_ff) begin
         rsp_vld_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff <= mrc_pkg::SLAVE_ADDR_RESET;
      end else if (csr_wr_en) begin
         addr_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_vld_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_chan.rx_byte;
         in_last_ff <= req_chan.frame_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_last_ff) begin
         rsp_ff <= result;
      end
   end

   assign rsp_chan.valid     = rsp_vld_ff;
   assign rsp_chan.status    = rsp_ff.status;
   assign rsp_chan.reg_value = rsp_ff.reg_value;

`ifndef SYNTHESIS
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff |-> (rsp_ff.status == mrc_pkg::STATUS_OK ||
                      rsp_ff.status == mrc_pkg::STATUS_FORMAT ||
                      rsp_ff.status == mrc_pkg::STATUS_CRC))
      else $error("status word carries an unknown code");

   a_value_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && rsp_ff.status != mrc_pkg::STATUS_OK |-> rsp_ff.reg_value == '0)
      else $error("reg_value nonzero on a failed frame");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      in_vld_ff && !advance |-> in_last_ff && rsp_vld_ff && !rsp_chan.ready)
      else $error("input register stalled without a waiting status word");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      in_vld_ff && !advance |=> in_vld_ff && in_last_ff && $stable(in_byte_ff))
      else $error("stalled final byte lost");
`endif

endmodule

// File: verif/tb_modbus_register_reply_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_modbus_register_reply_checker
// Sends reply frames byte by byte into the checker: well-formed replies,
// replies with a broken header or crc, short frames, noise and one frame past
// the receive bound. Each byte taken is run through a cycle-free model of the
// checker; every status word coming back is compared with the oldest
// prediction. Both channels idle at random, with one phase at full rate.
// ----------------------------------------------------------------------------
module tb_modbus_register_reply_checker;

   localparam int unsigned BYTE_W        = mrc_pkg::BYTE_W;
   localparam int unsigned WORD_W        = mrc_pkg::WORD_W;
   localparam int unsigned STAT_W        = mrc_pkg::STAT_W;
   localparam int unsigned FRAME_LIMIT   = 512;
   localparam int unsigned CYCLE_LIMIT   = 100000;
   localparam int unsigned SETTLE_CYCLES = 8;

   typedef enum int {
      FR_GOOD,
      FR_BAD_HEADER,
      FR_BAD_CRC,
      FR_SHORT,
      FR_NOISE,
      FR_SINGLE,
      FR_LONG
   } frame_kind_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              last;
   } rx_word_type;

   logic              clock = 1'b0;
   logic              reset;
   logic              csr_wr_en;
   logic [BYTE_W-1:0] csr_wr_data;

   mrc_req_if req_ch ();
   mrc_rsp_if rsp_ch ();

   modbus_register_reply_checker #(
      .MAX_FRAME_BYTES(FRAME_LIMIT)
   ) uut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_ch),
      .rsp_chan    (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   rx_word_type          rx_words[$];
   mrc_pkg::result_type  expected_replies[$];
   rx_word_type          next_word;
   int unsigned idle_pct = 14;
   int unsigned errors = 0;
   int unsigned words_queued = 0;
   int unsigned ok_seen = 0;
   int unsigned format_seen = 0;
   int unsigned crc_seen = 0;
   int unsigned cycle_count = 0;

   // model copy of the address register and the frame state
   logic [BYTE_W-1:0] dev_addr = mrc_pkg::SLAVE_ADDR_RESET;
   logic [9:0]        frame_bytes;
   logic              header_good;
   logic [WORD_W-1:0] crc_run;
   logic [WORD_W-1:0] crc_prev1;
   logic [WORD_W-1:0] crc_prev2;
   logic [WORD_W-1:0] reg_word;
   logic [WORD_W-1:0] last_two;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic logic [WORD_W-1:0] crc16_update(input logic [WORD_W-1:0] acc,
                                                      input logic [BYTE_W-1:0] data);
      logic [WORD_W-1:0] r;
      r = acc ^ WORD_W'(data);
      repeat (BYTE_W) r = r[0] ? ((r >> 1) ^ mrc_pkg::CRC_POLY) : (r >> 1);
      return r;
   endfunction

   task automatic clear_frame_state();
      frame_bytes = '0;
      header_good = 1'b1;
      crc_run     = mrc_pkg::CRC_INIT;
      crc_prev1   = mrc_pkg::CRC_INIT;
      crc_prev2   = mrc_pkg::CRC_INIT;
      reg_word    = '0;
      last_two    = '0;
   endtask

   task automatic track_rx_word(input logic [BYTE_W-1:0] data, input logic last);
      mrc_pkg::result_type r;
      if (frame_bytes < FRAME_LIMIT) begin
         case (frame_bytes)
            10'd0: begin
               if (data != dev_addr) header_good = 1'b0;
            end
            10'd1: begin
               if (data != mrc_pkg::FUNC_READ_HOLDING) header_good = 1'b0;
            end
            10'd2: begin
               if (data != mrc_pkg::DATA_BYTE_COUNT) header_good = 1'b0;
            end
            10'd3: reg_word[15:8] = data;
            10'd4: reg_word[7:0] = data;
            default: ;
         endcase
         crc_prev2   = crc_prev1;
         crc_prev1   = crc_run;
         crc_run     = crc16_update(crc_run, data);
         last_two    = {last_two[7:0], data};
         frame_bytes = frame_bytes + 10'd1;
      end
      if (last) begin
         r.reg_value = '0;
         if (frame_bytes < mrc_pkg::MIN_FRAME_BYTES || !header_good) begin
            r.status = mrc_pkg::STATUS_FORMAT;
         end else if ({last_two[7:0], last_two[15:8]} != crc_prev2) begin
            r.status = mrc_pkg::STATUS_CRC;
         end else begin
            r.status    = mrc_pkg::STATUS_OK;
            r.reg_value = reg_word;
         end
         expected_replies.push_back(r);
         clear_frame_state();
      end
   endtask

   task automatic check_reply(input logic [STAT_W-1:0] got_status,
                              input logic [WORD_W-1:0] got_value);
      mrc_pkg::result_type want;
      if (expected_replies.size() == 0) begin
         $display("%0t: status word with none expected: status %0d reg_value %h",
                  $time, got_status, got_value);
         errors++;
      end else begin
         want = expected_replies.pop_front();
         if (got_status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, got_status);
            errors++;
         end
         if (got_value !== want.reg_value) begin
            $display("%0t: reg_value expected %h actual %h", $time, want.reg_value, got_value);
            errors++;
         end
         case (want.status)
            mrc_pkg::STATUS_OK:     ok_seen++;
            mrc_pkg::STATUS_FORMAT: format_seen++;
            default:                crc_seen++;
         endcase
      end
   endtask

   task automatic send_frame(input frame_kind_type kind, input int unsigned len,
                             input logic [WORD_W-1:0] value);
      logic [BYTE_W-1:0] f[$];
      logic [WORD_W-1:0] c;
      rx_word_type       w;
      int unsigned       good_len;
      int unsigned       pos;
      f = {};
      if (kind == FR_NOISE || kind == FR_SINGLE) begin
         repeat (len) f.push_back(BYTE_W'($urandom_range(255)));
      end else begin
         good_len = (kind == FR_LONG) ? FRAME_LIMIT : (kind == FR_SHORT) ? 7 : len;
         f.push_back(dev_addr);
         f.push_back(mrc_pkg::FUNC_READ_HOLDING);
         f.push_back(mrc_pkg::DATA_BYTE_COUNT);
         f.push_back(value[15:8]);
         f.push_back(value[7:0]);
         while (f.size() < good_len - 2) f.push_back(BYTE_W'($urandom_range(255)));
         c = mrc_pkg::CRC_INIT;
         foreach (f[i]) c = crc16_update(c, f[i]);
         f.push_back(c[7:0]);
         f.push_back(c[15:8]);
         case (kind)
            FR_BAD_HEADER: begin
               pos = $urandom_range(2);
               f[pos] = f[pos] ^ BYTE_W'($urandom_range(1, 255));
            end
            FR_BAD_CRC: begin
               pos = $urandom_range(3, f.size() - 1);
               f[pos] = f[pos] ^ BYTE_W'($urandom_range(1, 255));
            end
            FR_SHORT: begin
               while (f.size() > len) void'(f.pop_back());
            end
            FR_LONG: begin
               while (f.size() < len) f.push_back(BYTE_W'($urandom_range(255)));
            end
            default: ;
         endcase
      end
      foreach (f[i]) begin
         w.data = f[i];
         w.last = (i == f.size() - 1);
         rx_words.push_back(w);
         words_queued++;
      end
   endtask

   task automatic random_frames(input int unsigned budget);
      int unsigned       start;
      int unsigned       pick;
      int unsigned       len;
      logic [WORD_W-1:0] value;
      start = words_queued;
      while (words_queued - start < budget) begin
         pick  = $urandom_range(99);
         len   = ($urandom_range(99) < 70) ? 7 : $urandom_range(8, 12);
         case ($urandom_range(9))
            0:       value = '0;
            1:       value = '1;
            default: value = WORD_W'($urandom_range(16'hFFFF));
         endcase
         if (pick < 55) begin
            send_frame(FR_GOOD, len, value);
         end else if (pick < 65) begin
            send_frame(FR_BAD_HEADER, len, value);
         end else if (pick < 75) begin
            send_frame(FR_BAD_CRC, len, value);
         end else if (pick < 85) begin
            send_frame(FR_SHORT, $urandom_range(1, 6), value);
         end else if (pick < 93) begin
            send_frame(FR_NOISE, $urandom_range(1, 12), value);
         end else begin
            send_frame(FR_SINGLE, 1, value);
         end
      end
   endtask

   task automatic wait_idle();
      while (rx_words.size() > 0 || req_ch.valid || expected_replies.size() > 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_address(input logic [BYTE_W-1:0] addr);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= addr;
      dev_addr     = addr;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // byte driver
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            track_rx_word(req_ch.rx_byte, req_ch.frame_end);
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (rx_words.size() > 0 && $urandom_range(99) >= idle_pct) begin
               next_word         = rx_words.pop_front();
               req_ch.valid     <= 1'b1;
               req_ch.rx_byte   <= next_word.data;
               req_ch.frame_end <= next_word.last;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // status word monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            check_reply(rsp_ch.status, rsp_ch.reg_value);
         end
         rsp_ch.ready <= ($urandom_range(99) >= idle_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("modbus_register_reply_checker: mismatch");
         $finish;
      end
   end

   initial begin
      reset            = 1'b1;
      csr_wr_en        = 1'b0;
      csr_wr_data      = '0;
      req_ch.valid     = 1'b0;
      req_ch.rx_byte   = '0;
      req_ch.frame_end = 1'b0;
      rsp_ch.ready     = 1'b0;
      clear_frame_state();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed frames at the reset address
      send_frame(FR_GOOD, 7, 16'hFFFF);
      send_frame(FR_BAD_HEADER, 7, 16'h0000);
      send_frame(FR_BAD_CRC, 7, 16'h0000);
      send_frame(FR_SHORT, 3, 16'h1234);
      send_frame(FR_SINGLE, 1, 16'h0000);
      wait_idle();

      set_address(8'h00);
      random_frames(200);
      wait_idle();

      set_address(8'hFF);
      random_frames(200);
      wait_idle();

      // frame past the receive bound, then one exactly at it
      set_address(BYTE_W'($urandom_range(255)));
      send_frame(FR_LONG, $urandom_range(FRAME_LIMIT + 1, FRAME_LIMIT + 18),
                 WORD_W'($urandom_range(16'hFFFF)));
      send_frame(FR_GOOD, FRAME_LIMIT, WORD_W'($urandom_range(16'hFFFF)));
      random_frames(70);
      wait_idle();

      // full rate on both sides
      idle_pct = 0;
      set_address(BYTE_W'($urandom_range(255)));
      random_frames(150);
      wait_idle();

      $display("checked %0d status words (%0d ok, %0d format, %0d crc) from %0d bytes",
               ok_seen + format_seen + crc_seen, ok_seen, format_seen, crc_seen,
               words_queued);
      $display("covered reset, all-zero, all-one and random device addresses, a full-rate %s",
               "phase and frames at and past the receive bound");
      if (errors == 0) begin
         $display("modbus_register_reply_checker: match");
      end else begin
         $display("modbus_register_reply_checker: mismatch");
      end
      $finish;
   end

endmodule

// File: filelist.f
hw/rtl/mrc_pkg.sv
hw/rtl/mrc_if.sv
hw/rtl/mrc_frame.sv
hw/rtl/modbus_register_reply_checker.sv
verif/tb_modbus_register_reply_checker.sv
